>>> hdl/adtsfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adtsfs_pkg
// Shared types and constants of the ADTS frame splitter.
// ----------------------------------------------------------------------------
package adtsfs_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 13;
  localparam int unsigned FNUM_W  = 16;
  localparam int unsigned BEAT_W  = 3;

  // Default depth of the job queue between parser and emitter
  localparam int unsigned QUEUE_DEPTH = 4;

  // Sync pattern and header layout
  localparam logic [BYTE_W-1:0] SYNC_BYTE    = 8'hFF;
  localparam logic [3:0]        SYNC_NIBBLE  = 4'hF;
  localparam logic [LEN_W-1:0]  MIN_LEN      = 13'd7;
  localparam logic [LEN_W-1:0]  LEN_POS_BYTE = 13'd5;  // byte that completes the length

  // Emitter beat numbers for a header job: sync byte, bytes 1..4, byte 5
  localparam logic [BEAT_W-1:0] BEAT_SYNC = 3'd0;
  localparam logic [BEAT_W-1:0] BEAT_H1   = 3'd1;
  localparam logic [BEAT_W-1:0] BEAT_H2   = 3'd2;
  localparam logic [BEAT_W-1:0] BEAT_H3   = 3'd3;
  localparam logic [BEAT_W-1:0] BEAT_H4   = 3'd4;
  localparam logic [BEAT_W-1:0] BEAT_LAST = 3'd5;

  // Parser phase
  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_SYNC = 2'd1,
    PH_HEAD = 2'd2,
    PH_BODY = 2'd3
  } phase_t;

  // One job from parser to emitter: a header job expands into six bytes,
  // a body job into one
  typedef struct packed {
    logic              hdr;
    logic              last;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  size;
    logic [FNUM_W-1:0] number;
    logic [BYTE_W-1:0] h1;
    logic [BYTE_W-1:0] h2;
    logic [BYTE_W-1:0] h3;
    logic [BYTE_W-1:0] h4;
  } job_t;

endpackage

>>> hdl/adtsfs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adtsfs_front
// Byte parser: hunts for the syncword, collects the header, checks the
// frame length and issues header and body jobs.
// ----------------------------------------------------------------------------
module adtsfs_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       take,
  input  logic [adtsfs_pkg::BYTE_W-1:0] stream_byte,
  output logic                       job_push,
  output adtsfs_pkg::job_t           job
);

  adtsfs_pkg::phase_t                phase, phase_next;
  logic [adtsfs_pkg::LEN_W-1:0]      byte_position, byte_position_next;
  logic [adtsfs_pkg::LEN_W-1:0]      current_length, current_length_next;
  logic [adtsfs_pkg::FNUM_W-1:0]     frame_counter, frame_counter_next;
  logic [adtsfs_pkg::BYTE_W-1:0]     h1, h2, h3, h4;
  logic [adtsfs_pkg::LEN_W-1:0]      len;
  logic [adtsfs_pkg::LEN_W:0]        pos_inc;
  logic                              body_last;
  logic                              hdr_push;

  // Length field from bytes 3, 4 and the current byte 5
  assign len       = {h3[1:0], h4, stream_byte[7:5]};
  assign pos_inc   = {1'b0, byte_position} + 14'd1;
  assign body_last = (pos_inc >= {1'b0, current_length});

  // Next state and job issue
  always_comb begin
    phase_next          = phase;
    byte_position_next  = byte_position;
    current_length_next = current_length;
    frame_counter_next  = frame_counter;
    job_push            = 1'b0;
    hdr_push            = 1'b0;
    unique case (phase)
      adtsfs_pkg::PH_HUNT: begin
        if (stream_byte == adtsfs_pkg::SYNC_BYTE) begin
          byte_position_next = 13'd1;
          phase_next         = adtsfs_pkg::PH_SYNC;
        end
      end
      adtsfs_pkg::PH_SYNC: begin
        if (stream_byte[7:4] == adtsfs_pkg::SYNC_NIBBLE) begin
          byte_position_next = 13'd2;
          phase_next         = adtsfs_pkg::PH_HEAD;
        end else if (stream_byte == adtsfs_pkg::SYNC_BYTE) begin
          byte_position_next = 13'd1;
        end else begin
          byte_position_next = '0;
          phase_next         = adtsfs_pkg::PH_HUNT;
        end
      end
      adtsfs_pkg::PH_HEAD: begin
        if (byte_position < adtsfs_pkg::LEN_POS_BYTE) begin
          byte_position_next = pos_inc[adtsfs_pkg::LEN_W-1:0];
        end else if (len < adtsfs_pkg::MIN_LEN) begin
          // short length: drop the header, hunt again
          byte_position_next  = '0;
          current_length_next = '0;
          phase_next          = adtsfs_pkg::PH_HUNT;
        end else begin
          current_length_next = len;
          byte_position_next  = 13'd6;
          phase_next          = adtsfs_pkg::PH_BODY;
          job_push            = 1'b1;
          hdr_push            = 1'b1;
        end
      end
      adtsfs_pkg::PH_BODY: begin
        job_push = 1'b1;
        if (body_last) begin
          frame_counter_next = frame_counter + 16'd1;
          byte_position_next = '0;
          phase_next         = adtsfs_pkg::PH_HUNT;
        end else begin
          byte_position_next = pos_inc[adtsfs_pkg::LEN_W-1:0];
        end
      end
      default: begin
        phase_next = adtsfs_pkg::PH_HUNT;
      end
    endcase
    job_push = job_push & take;
  end

  // Job payload; a header job carries the new length
  always_comb begin
    job.hdr    = hdr_push;
    job.last   = ~hdr_push & body_last;
    job.data   = stream_byte;
    job.size   = hdr_push ? len : current_length;
    job.number = frame_counter;
    job.h1     = h1;
    job.h2     = h2;
    job.h3     = h3;
    job.h4     = h4;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= adtsfs_pkg::PH_HUNT;
      byte_position  <= '0;
      current_length <= '0;
      frame_counter  <= '0;
    end else if (take) begin
      phase          <= phase_next;
      byte_position  <= byte_position_next;
      current_length <= current_length_next;
      frame_counter  <= frame_counter_next;
    end
  end

  // Header hold; byte 0 is always the sync byte and is not stored
  always_ff @(posedge clk) begin
    if (take) begin
      if (phase == adtsfs_pkg::PH_SYNC &&
          stream_byte[7:4] == adtsfs_pkg::SYNC_NIBBLE) begin
        h1 <= stream_byte;
      end
      if (phase == adtsfs_pkg::PH_HEAD) begin
        case (byte_position[2:0])
          3'd2:    h2 <= stream_byte;
          3'd3:    h3 <= stream_byte;
          3'd4:    h4 <= stream_byte;
          default: ;
        endcase
      end
    end
  end

endmodule

>>> hdl/adtsfs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adtsfs_queue
// Small job queue between parser and emitter.
// ----------------------------------------------------------------------------
module adtsfs_queue #(
  parameter int unsigned DEPTH = adtsfs_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  adtsfs_pkg::job_t wr_job,
  input  logic             rd,
  output adtsfs_pkg::job_t rd_job,
  output logic             full,
  output logic             empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  adtsfs_pkg::job_t mem [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr, do_rd;

  assign full   = (count == CW'(DEPTH));
  assign empty  = (count == '0);
  assign do_wr  = wr & ~full;
  assign do_rd  = rd & ~empty;
  assign rd_job = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hdl/adtsfs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adtsfs_back
// Emitter: expands jobs into result bytes, decodes the header fields and
// holds each result in an output register until it is popped.
// ----------------------------------------------------------------------------
module adtsfs_back (
  input  logic                           clk,
  input  logic                           rst,
  input  adtsfs_pkg::job_t               job,
  input  logic                           job_empty,
  output logic                           job_pop,
  input  logic                           pop,
  output logic                           empty,
  output logic [adtsfs_pkg::BYTE_W-1:0]  frame_byte,
  output logic                           is_first,
  output logic                           is_last,
  output logic [adtsfs_pkg::LEN_W-1:0]   frame_size,
  output logic [adtsfs_pkg::FNUM_W-1:0]  frame_number,
  output logic                           mpeg_version,
  output logic [1:0]                     profile_code,
  output logic [3:0]                     sampling_index,
  output logic [2:0]                     channel_config
);

  logic                           out_valid;
  logic                           slot_free;
  logic                           load;
  logic [adtsfs_pkg::BEAT_W-1:0]  beat;
  logic [adtsfs_pkg::BYTE_W-1:0]  beat_byte;

  assign slot_free = ~out_valid | pop;
  assign load      = slot_free & ~job_empty;
  assign job_pop   = load & (~job.hdr | (beat == adtsfs_pkg::BEAT_LAST));
  assign empty     = ~out_valid;

  // Byte of the current beat
  always_comb begin
    if (!job.hdr) begin
      beat_byte = job.data;
    end else begin
      unique case (beat)
        adtsfs_pkg::BEAT_SYNC: beat_byte = adtsfs_pkg::SYNC_BYTE;
        adtsfs_pkg::BEAT_H1:   beat_byte = job.h1;
        adtsfs_pkg::BEAT_H2:   beat_byte = job.h2;
        adtsfs_pkg::BEAT_H3:   beat_byte = job.h3;
        adtsfs_pkg::BEAT_H4:   beat_byte = job.h4;
        default:               beat_byte = job.data;
      endcase
    end
  end

  // Beat counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      beat      <= adtsfs_pkg::BEAT_SYNC;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        beat <= job_pop ? adtsfs_pkg::BEAT_SYNC : beat + 1'b1;
      end
      if (slot_free) begin
        out_valid <= ~job_empty;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (load) begin
      frame_byte     <= beat_byte;
      is_first       <= job.hdr & (beat == adtsfs_pkg::BEAT_SYNC);
      is_last        <= job.last;
      frame_size     <= job.size;
      frame_number   <= job.number;
      mpeg_version   <= job.h1[3];
      profile_code   <= job.h2[7:6];
      sampling_index <= job.h2[5:2];
      channel_config <= {job.h2[0], job.h3[7:6]};
    end
  end

endmodule

>>> hdl/adts_frame_splitter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adts_frame_splitter_unit
// ADTS byte stream deframer with queue handshakes on both sides.
// ----------------------------------------------------------------------------
// Input: one stream byte per transaction (push while full is low). Output:
// one frame byte per transaction with its frame length, frame number,
// header fields and first/last marks (pop while empty is low).
// The parser takes one byte per cycle whenever its job queue has room.
// Bytes outside a frame and header bytes 0..4 give no result. Byte 5 of a
// valid header gives six results, emitted one per cycle while the receiver
// keeps popping; each payload byte gives one result. A result passes
// through the job queue and the output register before it reaches the ports.
// Sustained rate: one byte per cycle in payload while the receiver pops. The
// six-beat header expansion can fill the queue and stall the input; full
// drops as soon as a job leaves the queue.
// If the receiver stalls, the held result stays on the ports, the queue
// fills and full rises. Reset (rst, synchronous) empties the queue and the
// output register and restarts the sync hunt and the frame count at zero.
// ----------------------------------------------------------------------------
module adts_frame_splitter_unit #(
  parameter int unsigned QUEUE_DEPTH = adtsfs_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [adtsfs_pkg::BYTE_W-1:0] stream_byte,
  input  logic                          pop,
  output logic                          empty,
  output logic [adtsfs_pkg::BYTE_W-1:0] frame_byte,
  output logic                          is_first,
  output logic                          is_last,
  output logic [adtsfs_pkg::LEN_W-1:0]  frame_size,
  output logic [adtsfs_pkg::FNUM_W-1:0] frame_number,
  output logic                          mpeg_version,
  output logic [1:0]                    profile_code,
  output logic [3:0]                    sampling_index,
  output logic [2:0]                    channel_config
);

  logic             take;
  logic             job_push;
  logic             job_pop;
  logic             q_empty;
  adtsfs_pkg::job_t job_in, job_out;

  assign take = push & ~full;

  // Parser
  adtsfs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .stream_byte (stream_byte),
    .job_push    (job_push),
    .job         (job_in)
  );

  // Job queue
  adtsfs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (job_push),
    .wr_job (job_in),
    .rd     (job_pop),
    .rd_job (job_out),
    .full   (full),
    .empty  (q_empty)
  );

  // Emitter
  adtsfs_back u_back (
    .clk            (clk),
    .rst            (rst),
    .job            (job_out),
    .job_empty      (q_empty),
    .job_pop        (job_pop),
    .pop            (pop),
    .empty          (empty),
    .frame_byte     (frame_byte),
    .is_first       (is_first),
    .is_last        (is_last),
    .frame_size     (frame_size),
    .frame_number   (frame_number),
    .mpeg_version   (mpeg_version),
    .profile_code   (profile_code),
    .sampling_index (sampling_index),
    .channel_config (channel_config)
  );

endmodule

>>> hdl/adtsfs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adtsfs_checker
// Port-level checks of the ADTS frame splitter, bound to the top level.
// ----------------------------------------------------------------------------
module adtsfs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          pop,
  input logic                          empty,
  input logic [adtsfs_pkg::BYTE_W-1:0] frame_byte,
  input logic                          is_first,
  input logic                          is_last,
  input logic [adtsfs_pkg::LEN_W-1:0]  frame_size
);

  // Nothing to show right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result present after reset");

  // A frame start is always the sync byte
  a_first_sync: assert property (@(posedge clk) disable iff (rst)
    (!empty && is_first) |-> (frame_byte == adtsfs_pkg::SYNC_BYTE))
    else $error("frame start is not the sync byte");

  // Emitted frames are never shorter than the minimum header length, and a frame start never carries the last mark
  a_min_len: assert property (@(posedge clk) disable iff (rst)
    (!empty && is_first) |-> (frame_size >= adtsfs_pkg::MIN_LEN) && !is_last)
    else $error("frame start with short length or last mark");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(frame_byte) && $stable(is_last)))
    else $error("stalled result changed");

endmodule

bind adts_frame_splitter_unit adtsfs_checker u_adtsfs_checker (
  .clk        (clk),
  .rst        (rst),
  .pop        (pop),
  .empty      (empty),
  .frame_byte (frame_byte),
  .is_first   (is_first),
  .is_last    (is_last),
  .frame_size (frame_size)
);
